/* src/lat_pkg.sv */
// ---------------------------------------------------------------------------
// Launch acceleration timer package
// Field widths, reset values of the limit registers, command codes and
// register indexes that the timer uses.
// ---------------------------------------------------------------------------
package lat_pkg;

   localparam int SPEED_W = 12;
   localparam int TIME_W  = 32;
   localparam int CMD_W   = 2;
   localparam int CSR_ADDR_W = 2;

   // Packed widths of the stream payloads, rounded up to whole bytes.
   localparam int REQ_BITS = CMD_W + SPEED_W + 1 + TIME_W;
   localparam int RSP_BITS = 3 + TIME_W + TIME_W + 1;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ARM    = 2'd2;

   // Limit register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_REST_LIMIT   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LAUNCH_LIMIT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TARGET_SPEED = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_RESET_REST   = 2'd3;

   // Reset values of the limit registers, in 0.1 km/h.
   localparam logic [SPEED_W-1:0] REST_LIMIT_RST   = 12'd2;
   localparam logic [SPEED_W-1:0] LAUNCH_LIMIT_RST = 12'd8;
   localparam logic [SPEED_W-1:0] TARGET_SPEED_RST = 12'd1000;
   localparam logic [SPEED_W-1:0] RESET_REST_RST   = 12'd5;

   // One input item as held in the input register.
   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic               throttle_on;
      logic [SPEED_W-1:0] speed;
      logic [CMD_W-1:0]   cmd;
   } req_item_type;

   // One result item as held in the result register.
   typedef struct packed {
      logic               updated;
      logic [TIME_W-1:0]  best_time_ms;
      logic [TIME_W-1:0]  run_time_ms;
      logic               finished;
      logic               running;
      logic               armed;
   } rsp_item_type;

endpackage

/* src/launch_acceleration_timer.sv */
// ---------------------------------------------------------------------------
// Launch acceleration timer
// Times a standing start from rest to a target speed and keeps the best run.
// ---------------------------------------------------------------------------
// Each item on the req_ stream carries a command (sample, reset or arm), the
// vehicle speed in 0.1 km/h, the throttle flag and a free-running millisecond
// stamp. Every item yields exactly one result item on the rsp_ stream with the
// armed, running and finished flags, the current or last run time, the best
// time (zero means none yet) and an updated flag.
// An accepted item lands in the input register; when it moves on, the timer
// state and the result register are updated from it and rsp_tvalid rises, and
// the result can be taken once the receiver raises rsp_tready. One item is
// taken every cycle as long as the result register is free or is being drained
// in the same cycle.
// When the receiver holds rsp_tready low, the result waits in the result
// register, the next item waits in the input register, and req_tready drops
// only once both are full.
// The csr_ port writes the four speed limits; it is meant to be used only
// while no item is in flight. Synchronous reset empties both registers,
// clears the run state and the best time and restores the default limits.
// ---------------------------------------------------------------------------
module launch_acceleration_timer (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: cmd[1:0], speed[13:2], throttle_on[14], now_ms[46:15], zero pad
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lat_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: armed[0], running[1], finished[2], run_time_ms[34:3],
   // best_time_ms[66:35], updated[67], zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lat_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [lat_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [lat_pkg::SPEED_W-1:0]         csr_wdata
);

   // Speed limit registers.
   logic [lat_pkg::SPEED_W-1:0] rest_limit_ff;
   logic [lat_pkg::SPEED_W-1:0] launch_limit_ff;
   logic [lat_pkg::SPEED_W-1:0] target_speed_ff;
   logic [lat_pkg::SPEED_W-1:0] reset_rest_ff;

   // Input register.
   logic                  req_valid_ff;
   lat_pkg::req_item_type req_item_ff;
   logic                  req_advance;

   // Result register.
   logic                  rsp_valid_ff;
   lat_pkg::rsp_item_type rsp_item_ff;
   lat_pkg::rsp_item_type rsp_item_in;

   // Timer state.
   logic                       armed_ff, armed_in;
   logic                       running_ff, running_in;
   logic                       finished_ff, finished_in;
   logic [lat_pkg::TIME_W-1:0] start_ff, start_in;
   logic [lat_pkg::TIME_W-1:0] run_time_ff, run_time_in;
   logic [lat_pkg::TIME_W-1:0] best_ff, best_in;
   logic                       updated_in;

   logic                       idle;
   logic                       armed_now;
   logic [lat_pkg::TIME_W-1:0] elapsed;

   // The input register moves on whenever the result register is empty or is
   // being drained this cycle, so the input side only stalls when both hold.
   assign req_advance = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !req_valid_ff || req_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_limit_ff   <= lat_pkg::REST_LIMIT_RST;
         launch_limit_ff <= lat_pkg::LAUNCH_LIMIT_RST;
         target_speed_ff <= lat_pkg::TARGET_SPEED_RST;
         reset_rest_ff   <= lat_pkg::RESET_REST_RST;
      end else if (csr_we) begin
         case (csr_addr)
            lat_pkg::REG_REST_LIMIT:   rest_limit_ff   <= csr_wdata;
            lat_pkg::REG_LAUNCH_LIMIT: launch_limit_ff <= csr_wdata;
            lat_pkg::REG_TARGET_SPEED: target_speed_ff <= csr_wdata;
            lat_pkg::REG_RESET_REST:   reset_rest_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_item_ff <= lat_pkg::req_item_type'(req_tdata[lat_pkg::REQ_BITS-1:0]);
      end
   end

   // Timer state is idle when no run is in progress and none is finished.
   assign idle      = !running_ff && !finished_ff;
   assign armed_now = armed_ff ||
                      (idle && (req_item_ff.speed < rest_limit_ff));
   assign elapsed   = req_item_ff.now_ms - start_ff;

   always_comb begin
      armed_in    = armed_ff;
      running_in  = running_ff;
      finished_in = finished_ff;
      start_in    = start_ff;
      run_time_in = run_time_ff;
      best_in     = best_ff;
      updated_in  = 1'b0;
      case (req_item_ff.cmd)
         lat_pkg::CMD_SAMPLE: begin
            armed_in = armed_now;
            if (armed_now && idle) begin
               // Launch: the car moves past the launch limit with throttle.
               if ((req_item_ff.speed > launch_limit_ff) && req_item_ff.throttle_on) begin
                  armed_in   = 1'b0;
                  running_in = 1'b1;
                  start_in   = req_item_ff.now_ms;
                  updated_in = 1'b1;
               end
            end else if (running_ff && !finished_ff) begin
               run_time_in = elapsed;
               updated_in  = 1'b1;
               if (req_item_ff.speed >= target_speed_ff) begin
                  running_in  = 1'b0;
                  finished_in = 1'b1;
                  // A best time of zero reads as no best yet.
                  if ((best_ff == '0) || (elapsed < best_ff)) begin
                     best_in = elapsed;
                  end
               end
            end
         end
         lat_pkg::CMD_RESET: begin
            running_in  = 1'b0;
            finished_in = 1'b0;
            run_time_in = '0;
            armed_in    = req_item_ff.speed < reset_rest_ff;
            updated_in  = 1'b1;
         end
         lat_pkg::CMD_ARM: begin
            running_in  = 1'b0;
            finished_in = 1'b0;
            run_time_in = '0;
            armed_in    = 1'b1;
            updated_in  = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_item_in.armed        = armed_in;
      rsp_item_in.running      = running_in;
      rsp_item_in.finished     = finished_in;
      rsp_item_in.run_time_ms  = run_time_in;
      rsp_item_in.best_time_ms = best_in;
      rsp_item_in.updated      = updated_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= 1'b0;
         running_ff  <= 1'b0;
         finished_ff <= 1'b0;
         start_ff    <= '0;
         run_time_ff <= '0;
         best_ff     <= '0;
      end else if (req_advance) begin
         armed_ff    <= armed_in;
         running_ff  <= running_in;
         finished_ff <= finished_in;
         start_ff    <= start_in;
         run_time_ff <= run_time_in;
         best_ff     <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lat_pkg::RSP_DATA_W - lat_pkg::RSP_BITS){1'b0}}, rsp_item_ff};

`ifndef SYNTHESIS
   // A run is either in progress or finished, never both.
   assert property (@(posedge clock) disable iff (reset)
      !(running_ff && finished_ff))
      else $error("timer is running and finished at once");

   // Arming only happens with no run in progress or finished.
   assert property (@(posedge clock) disable iff (reset)
      !(armed_ff && (running_ff || finished_ff)))
      else $error("timer armed during or after a run");

   // The best time only moves when a run finishes.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(best_ff)) |-> finished_ff)
      else $error("best time changed without a finished run");

   // A held input item is never dropped while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !req_advance) |=> req_valid_ff)
      else $error("stalled item lost from the input register");
`endif

endmodule
